// ===== src/sample_mean_min_max_stddev_macros.svh =====
// ----------------------------------------------------------------------------
// sample statistics assertion macros
// shared property wrappers for the block level checks
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MEAN_MIN_MAX_STDDEV_MACROS_SVH
`define SAMPLE_MEAN_MIN_MAX_STDDEV_MACROS_SVH

// same-cycle implication
`define SMMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/smms_pkg.sv =====
// ----------------------------------------------------------------------------
// smms_pkg
// shared widths, types and sequencer states of the sample statistics block
// ----------------------------------------------------------------------------
package smms_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned MEAN_W       = 24;
  localparam int unsigned DEV_W        = 24;
  localparam int unsigned MAX_KEPT_DEF = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MEAN,
    ST_MEAN_W,
    ST_PASS,
    ST_VAR,
    ST_VAR_W,
    ST_ROOT,
    ST_ROOT_W,
    ST_EMIT
  } smms_state_e;

endpackage

// ===== src/smms_front.sv =====
// ----------------------------------------------------------------------------
// smms_front
// input side: takes sample beats and queues them for the back end
// ----------------------------------------------------------------------------
module smms_front import smms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  pop_i,
  output logic  q_valid_o,
  output item_t q_item_o
);

  item_t       ent_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== src/smms_div.sv =====
// ----------------------------------------------------------------------------
// smms_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smms_div import smms_pkg::*; #(
  parameter int unsigned W  = 56,
  parameter int unsigned DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  num_i,
  input  logic [DW-1:0] den_i,
  output logic [W-1:0]  quot_o,
  output unit_stat_t    stat_o
);

  localparam int unsigned STEP_W = $clog2(W + 1);

  logic [W-1:0]      quo_q, quo_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     den_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [DW:0]       shifted;
  logic              ge;
  logic              busy;

  assign busy    = (step_q != '0);
  assign shifted = {rem_q, quo_q[W-1]};
  assign ge      = (shifted >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      step_d = STEP_W'(W);
    end else if (busy) begin
      quo_d  = {quo_q[W-2:0], ge};
      rem_d  = ge ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      step_d = step_q - STEP_W'(1);
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy;
  assign stat_o.done = done_q;

endmodule

// ===== src/smms_sqrt.sv =====
// ----------------------------------------------------------------------------
// smms_sqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module smms_sqrt import smms_pkg::*; #(
  parameter int unsigned W = 56
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] rad_i,
  output logic [W-1:0] root_o,
  output unit_stat_t   stat_o
);

  logic [W-1:0] v_q, v_d;
  logic [W-1:0] root_q, root_d;
  logic [W-1:0] bit_q, bit_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [W:0]   trial;
  logic         ge;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign ge    = ({1'b0, v_q} >= trial);

  always_comb begin
    v_d    = v_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = rad_i;
      root_d = '0;
      bit_d  = W'(1) << (W - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        v_d    = v_q - trial[W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== src/smms_back.sv =====
// ----------------------------------------------------------------------------
// smms_back
// back end: accumulates kept samples, then mean, deviation pass, variance
// division and square root, and holds the result beat
// ----------------------------------------------------------------------------
module smms_back import smms_pkg::*; #(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  item_t                         q_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic        [COUNT_OUT_W-1:0] sample_count_o,
  output logic signed [SAMPLE_W-1:0]    maximum_o,
  output logic signed [SAMPLE_W-1:0]    minimum_o,
  output logic signed [MEAN_W-1:0]      mean_scaled_o,
  output logic        [DEV_W-1:0]       deviation_scaled_o,
  output logic                          overflowed_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int unsigned IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned D_W    = MEAN_W + 1;
  localparam int unsigned SQ_W   = 2 * D_W;
  localparam int unsigned ACC_W  = SQ_W + CNT_W;
  localparam int unsigned UNIT_W = ACC_W + (ACC_W % 2);

  smms_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] store [MAX_KEPT];

  logic        [CNT_W-1:0]    cnt_q, cnt_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic                       drop_q, drop_d;
  logic signed [MEAN_W-1:0]   mean_q;

  logic        [CNT_W-1:0]    rp_q;
  logic                       rdv_q, sqv_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic        [SQ_W-1:0]     sq_q;
  logic        [ACC_W-1:0]    acc_q;

  logic                       out_valid_q;
  logic        [COUNT_OUT_W-1:0] cnt_out_q;
  logic signed [SAMPLE_W-1:0] max_out_q, min_out_q;
  logic signed [MEAN_W-1:0]   mean_out_q;
  logic        [DEV_W-1:0]    dev_out_q;
  logic                       drop_out_q;

  logic                       pop, keep, first, emit_ok, emit;
  logic                       div_start, root_start, clr_pass, pass_run;
  logic                       rd_en, pass_done;
  logic                       sum_neg;
  logic        [SUM_W-1:0]    sum_mag;
  logic        [UNIT_W-1:0]   div_num;
  logic        [UNIT_W-1:0]   quot;
  logic        [UNIT_W-1:0]   root;
  logic        [MEAN_W-1:0]   mean_mag;
  logic signed [D_W-1:0]      diff;
  logic        [D_W-1:0]      diff_mag;
  unit_stat_t                 div_stat, root_stat;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (q_valid_i && q_item_i.last) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN:   state_d = ST_MEAN_W;
      ST_MEAN_W: begin
        if (div_stat.done) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_done) begin
          state_d = ST_VAR;
        end
      end
      ST_VAR:    state_d = ST_VAR_W;
      ST_VAR_W: begin
        if (div_stat.done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT:   state_d = ST_ROOT_W;
      ST_ROOT_W: begin
        if (root_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          state_d = ST_ACC;
        end
      end
      default:   state_d = ST_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    clr_pass   = 1'b0;
    pass_run   = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_ACC:  pop        = q_valid_i;
      ST_MEAN: begin
        div_start = 1'b1;
        clr_pass  = 1'b1;
      end
      ST_PASS: pass_run   = 1'b1;
      ST_VAR:  div_start  = 1'b1;
      ST_ROOT: root_start = 1'b1;
      ST_EMIT: emit       = emit_ok;
      default: pop        = 1'b0;
    endcase
  end

  assign pop_o   = pop;
  assign emit_ok = !out_valid_q || out_ready_i;

  // accumulation of kept samples
  assign keep  = pop && (cnt_q != CNT_W'(MAX_KEPT));
  assign first = (cnt_q == '0);

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    max_d  = max_q;
    min_d  = min_q;
    drop_d = drop_q;
    if (emit) begin
      cnt_d  = '0;
      sum_d  = '0;
      drop_d = 1'b0;
    end else if (keep) begin
      cnt_d = cnt_q + CNT_W'(1);
      sum_d = sum_q + SUM_W'(q_item_i.sample);
      if (first || (q_item_i.sample > max_q)) begin
        max_d = q_item_i.sample;
      end
      if (first || (q_item_i.sample < min_q)) begin
        min_d = q_item_i.sample;
      end
    end else if (pop) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      cnt_q   <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    min_q <= min_d;
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      store[cnt_q[IDX_W-1:0]] <= q_item_i.sample;
    end
  end

  // shared divider: scaled sum first, then squared deviations
  assign sum_neg  = sum_q[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_num  = (state_q == ST_MEAN) ? UNIT_W'({sum_mag, 8'h00}) : UNIT_W'(acc_q);
  assign mean_mag = quot[MEAN_W-1:0];

  smms_div #(
    .W  (UNIT_W),
    .DW (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cnt_q),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MEAN_W) && div_stat.done) begin
      mean_q <= sum_neg ? $signed(-mean_mag) : $signed(mean_mag);
    end
  end

  // deviation pass over the store
  assign rd_en     = pass_run && (rp_q != cnt_q);
  assign pass_done = pass_run && (rp_q == cnt_q) && !rdv_q && !sqv_q;
  assign diff      = $signed({{(D_W-MEAN_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q, 8'h00})
                   - D_W'(mean_q);
  assign diff_mag  = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      sqv_q <= 1'b0;
    end else begin
      rdv_q <= rd_en;
      sqv_q <= rdv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store[rp_q[IDX_W-1:0]];
    end
    sq_q <= diff_mag * diff_mag;
    if (clr_pass) begin
      rp_q  <= '0;
      acc_q <= '0;
    end else begin
      if (rd_en) begin
        rp_q <= rp_q + CNT_W'(1);
      end
      if (sqv_q) begin
        acc_q <= acc_q + ACC_W'(sq_q);
      end
    end
  end

  smms_sqrt #(
    .W (UNIT_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (quot),
    .root_o  (root),
    .stat_o  (root_stat)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cnt_out_q  <= COUNT_OUT_W'(cnt_q);
      max_out_q  <= max_q;
      min_out_q  <= min_q;
      mean_out_q <= mean_q;
      dev_out_q  <= root[DEV_W-1:0];
      drop_out_q <= drop_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sample_count_o     = cnt_out_q;
  assign maximum_o          = max_out_q;
  assign minimum_o          = min_out_q;
  assign mean_scaled_o      = mean_out_q;
  assign deviation_scaled_o = dev_out_q;
  assign overflowed_o       = drop_out_q;

endmodule

// ===== src/sample_mean_min_max_stddev.sv =====
// ----------------------------------------------------------------------------
// sample_mean_min_max_stddev
// block statistics over signed 16-bit samples: count, max, min, mean and
// population standard deviation, both scaled by 256
//
// samples come in on the in channel, one per beat, with last_sample_i set on
// the final beat of a block; one result beat leaves on the out channel per
// block. up to MAX_KEPT samples are kept; later ones are dropped and flag
// overflowed_o. a two-entry queue takes samples while the back end works.
// the back end takes a plain sample straight from the queue. to close a
// block, over an internal width W = 50 + clog2(MAX_KEPT+1) rounded up to
// even (56 at MAX_KEPT = 16), the one-bit-per-cycle divider runs twice
// (mean, variance), the deviation pass reads the store one entry a cycle
// and the square root makes one result bit a cycle.
// the result waits in an output register while the receiver stalls; the
// next block's samples keep flowing in until the queue fills behind a
// second finished block. reset clears the running state and drops any
// pending result; the sample store needs no clearing.
// ----------------------------------------------------------------------------
`include "sample_mean_min_max_stddev_macros.svh"

module sample_mean_min_max_stddev import smms_pkg::*; #(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_W-1:0]    sample_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic        [COUNT_OUT_W-1:0] sample_count_o,
  output logic signed [SAMPLE_W-1:0]    maximum_o,
  output logic signed [SAMPLE_W-1:0]    minimum_o,
  output logic signed [MEAN_W-1:0]      mean_scaled_o,
  output logic        [DEV_W-1:0]       deviation_scaled_o,
  output logic                          overflowed_o
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  pop;

  assign in_item.sample = sample_i;
  assign in_item.last   = last_sample_i;

  smms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .pop_i      (pop),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  smms_back #(
    .MAX_KEPT (MAX_KEPT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sample_count_o     (sample_count_o),
    .maximum_o          (maximum_o),
    .minimum_o          (minimum_o),
    .mean_scaled_o      (mean_scaled_o),
    .deviation_scaled_o (deviation_scaled_o),
    .overflowed_o       (overflowed_o)
  );

  `SMMS_ASSERT_IMP(a_max_ge_min, clk_i, rst_ni, out_valid_o, maximum_o >= minimum_o, "max below min")

  `SMMS_ASSERT_IMP(a_mean_in_range, clk_i, rst_ni, out_valid_o, ($signed({minimum_o, 8'h00}) <= mean_scaled_o) && (mean_scaled_o <= $signed({maximum_o, 8'h00})), "mean outside min/max")

  `SMMS_ASSERT_IMP(a_drop_full, clk_i, rst_ni, out_valid_o && overflowed_o, sample_count_o == COUNT_OUT_W'(MAX_KEPT), "drop with store not full")

endmodule
